// ===== hdl/sot_pkg.sv =====
// Shared constants, types and helpers of the sprite order table.
package sot_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_WIDTH   = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int CMD_W   = 3;
    localparam int POS_W   = 7;
    localparam int STAT_W  = 2;
    localparam int MODE_W  = 2;
    localparam int OP_W    = 5;

    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SORT   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd5;

    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SORTED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RENDER = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd3;

    localparam logic [STAT_W-1:0] ST_CHANGED = 2'd0;
    localparam logic [STAT_W-1:0] ST_SAME    = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    localparam logic [OP_W-1:0] OP_NONE    = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 5'd1;
    localparam logic [OP_W-1:0] OP_FRD     = 5'd2;
    localparam logic [OP_W-1:0] OP_FEV     = 5'd3;
    localparam logic [OP_W-1:0] OP_WR0     = 5'd4;
    localparam logic [OP_W-1:0] OP_FULL    = 5'd5;
    localparam logic [OP_W-1:0] OP_BS_INIT = 5'd6;
    localparam logic [OP_W-1:0] OP_BS_RD   = 5'd7;
    localparam logic [OP_W-1:0] OP_BS_EV   = 5'd8;
    localparam logic [OP_W-1:0] OP_SH_INIT = 5'd9;
    localparam logic [OP_W-1:0] OP_SH_RD   = 5'd10;
    localparam logic [OP_W-1:0] OP_SH_EV   = 5'd11;
    localparam logic [OP_W-1:0] OP_PUT     = 5'd12;
    localparam logic [OP_W-1:0] OP_RS_INIT = 5'd13;
    localparam logic [OP_W-1:0] OP_RS_EV   = 5'd14;
    localparam logic [OP_W-1:0] OP_RM_INIT = 5'd15;
    localparam logic [OP_W-1:0] OP_RM_RD   = 5'd16;
    localparam logic [OP_W-1:0] OP_RM_EV   = 5'd17;
    localparam logic [OP_W-1:0] OP_RM_END  = 5'd18;
    localparam logic [OP_W-1:0] OP_CLR     = 5'd19;
    localparam logic [OP_W-1:0] OP_SP_INIT = 5'd20;
    localparam logic [OP_W-1:0] OP_SP_LD   = 5'd21;
    localparam logic [OP_W-1:0] OP_SP_RD   = 5'd22;
    localparam logic [OP_W-1:0] OP_SP_EV   = 5'd23;
    localparam logic [OP_W-1:0] OP_SP_END  = 5'd24;
    localparam logic [OP_W-1:0] OP_UPD_RD  = 5'd25;
    localparam logic [OP_W-1:0] OP_UPD_EV  = 5'd26;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key;
        logic signed [15:0]   layer;
        logic signed [15:0]   y_pos;
    } t_entry;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [15:0]          sprite_key;
        logic signed [15:0]   layer;
        logic signed [15:0]   y_pos;
    } t_item;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [MODE_W-1:0] mode;
        logic              found;
        logic              idx_end;
        logic              idx_zero;
        logic              idx_at_ins;
        logic              bs_done;
        logic              rm_last;
        logic              sp_last;
        logic              hit;
        logic              count_zero;
        logic              count_full;
        logic              count_ge2;
        logic              out_free;
    } t_dp_stat;

    function automatic logic render_gt(input t_entry a, input t_entry b);
        render_gt = (a.layer > b.layer) || ((a.layer == b.layer) && (a.y_pos > b.y_pos));
    endfunction

endpackage

// ===== hdl/sot_datapath.sv =====
// Table memory, counters, working registers and result register of the sprite order table.
module sot_datapath import sot_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_item          i_item,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_data,
    input  t_ctl_cmd       i_cmd,
    input  logic           i_m_tready,
    output t_dp_stat       o_stat,
    output logic           o_m_tvalid,
    output logic [23:0]    o_m_tdata
);

    t_entry              mem [TABLE_DEPTH];
    t_entry              r_rdata;
    logic [ADDR_W-1:0]   raddr;
    logic [ADDR_W-1:0]   waddr;
    t_entry              wdata;
    logic                we;

    logic [MODE_W-1:0]   r_mode;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_back, n_back;
    logic [CMD_W-1:0]    r_command, n_command;
    t_entry              r_in, n_in;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_at, n_at;
    logic                r_found, n_found;
    logic [STAT_W-1:0]   r_status, n_status;
    logic [CNT_W-1:0]    r_lo, n_lo;
    logic [CNT_W-1:0]    r_hi, n_hi;
    logic [CNT_W-1:0]    r_ins, n_ins;
    t_entry              r_cur, n_cur;
    logic                r_swapped, n_swapped;
    logic                r_hit, n_hit;
    logic                r_out_valid;
    logic [23:0]         r_out;

    logic [CNT_W:0]      mid_sum;
    logic [CNT_W-1:0]    mid;
    logic [CNT_W:0]      idx_inc;
    logic [CNT_W-1:0]    idx_dec;

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CNT_W:1];
    assign idx_inc = {1'b0, r_idx} + {{CNT_W{1'b0}}, 1'b1};
    assign idx_dec = r_idx - {{(CNT_W-1){1'b0}}, 1'b1};

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_comb begin
        n_count   = r_count;
        n_back    = r_back;
        n_command = r_command;
        n_in      = r_in;
        n_idx     = r_idx;
        n_at      = r_at;
        n_found   = r_found;
        n_status  = r_status;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_ins     = r_ins;
        n_cur     = r_cur;
        n_swapped = r_swapped;
        n_hit     = r_hit;
        we        = 1'b0;
        waddr     = r_idx[ADDR_W-1:0];
        wdata     = r_rdata;
        raddr     = r_idx[ADDR_W-1:0];
        case (i_cmd.op)
            OP_LOAD: begin
                n_command = i_item.command;
                n_in.key  = i_item.sprite_key[KEY_WIDTH-1:0];
                n_in.layer = i_item.layer;
                n_in.y_pos = i_item.y_pos;
                n_idx     = '0;
                n_at      = '0;
                n_found   = 1'b0;
                n_status  = ST_SAME;
                n_hit     = 1'b0;
            end
            OP_FRD: begin
                raddr = r_idx[ADDR_W-1:0];
            end
            OP_FEV: begin
                if (r_rdata.key == r_in.key) begin
                    n_found = 1'b1;
                    n_at    = r_idx;
                end else begin
                    n_idx = idx_inc[CNT_W-1:0];
                end
            end
            OP_WR0: begin
                we       = 1'b1;
                waddr    = '0;
                wdata    = r_in;
                n_status = ST_CHANGED;
                n_found  = 1'b1;
                n_at     = '0;
            end
            OP_FULL: begin
                n_status = ST_FULL;
            end
            OP_BS_INIT: begin
                n_lo = '0;
                n_hi = r_count;
            end
            OP_BS_RD: begin
                raddr = mid[ADDR_W-1:0];
            end
            OP_BS_EV: begin
                if (r_in.key < r_rdata.key) begin
                    n_hi = mid;
                end else begin
                    n_lo = mid + {{(CNT_W-1){1'b0}}, 1'b1};
                end
            end
            OP_SH_INIT: begin
                n_ins = (r_mode == MODE_SORTED) ? r_lo : '0;
                n_idx = r_count;
            end
            OP_SH_RD: begin
                raddr = idx_dec[ADDR_W-1:0];
            end
            OP_SH_EV: begin
                we    = 1'b1;
                wdata = r_rdata;
                n_idx = idx_dec;
            end
            OP_PUT: begin
                we       = 1'b1;
                wdata    = r_in;
                n_count  = r_count + {{(CNT_W-1){1'b0}}, 1'b1};
                n_status = ST_CHANGED;
                n_found  = 1'b1;
                n_at     = r_idx;
            end
            OP_RS_INIT: begin
                n_idx = r_count;
                n_hit = 1'b0;
            end
            OP_RS_EV: begin
                if (!render_gt(r_rdata, r_in)) begin
                    n_hit = 1'b1;
                end else begin
                    we    = 1'b1;
                    wdata = r_rdata;
                    n_idx = idx_dec;
                end
            end
            OP_RM_INIT: begin
                n_idx = r_at;
            end
            OP_RM_RD: begin
                raddr = idx_inc[ADDR_W-1:0];
            end
            OP_RM_EV: begin
                we    = 1'b1;
                wdata = r_rdata;
                n_idx = idx_inc[CNT_W-1:0];
            end
            OP_RM_END: begin
                n_count  = r_count - {{(CNT_W-1){1'b0}}, 1'b1};
                n_status = ST_CHANGED;
                n_found  = 1'b0;
            end
            OP_CLR: begin
                n_status = (r_count != '0) ? ST_CHANGED : ST_SAME;
                n_count  = '0;
                n_found  = 1'b0;
                n_at     = '0;
            end
            OP_SP_INIT: begin
                n_idx     = r_back ? (r_count - {{(CNT_W-1){1'b0}}, 1'b1}) : '0;
                n_swapped = 1'b0;
            end
            OP_SP_LD: begin
                n_cur = r_rdata;
            end
            OP_SP_RD: begin
                raddr = r_back ? idx_dec[ADDR_W-1:0] : idx_inc[ADDR_W-1:0];
            end
            OP_SP_EV: begin
                we = 1'b1;
                if (r_back) begin
                    if (render_gt(r_rdata, r_cur)) begin
                        wdata     = r_rdata;
                        n_swapped = 1'b1;
                    end else begin
                        wdata = r_cur;
                        n_cur = r_rdata;
                    end
                    n_idx = idx_dec;
                end else begin
                    if (render_gt(r_cur, r_rdata)) begin
                        wdata     = r_rdata;
                        n_swapped = 1'b1;
                    end else begin
                        wdata = r_cur;
                        n_cur = r_rdata;
                    end
                    n_idx = idx_inc[CNT_W-1:0];
                end
            end
            OP_SP_END: begin
                we       = 1'b1;
                wdata    = r_cur;
                n_back   = ~r_back;
                n_status = r_swapped ? ST_CHANGED : ST_SAME;
                n_idx    = '0;
                n_found  = 1'b0;
                n_at     = '0;
            end
            OP_UPD_RD: begin
                raddr = r_at[ADDR_W-1:0];
            end
            OP_UPD_EV: begin
                if (r_rdata.layer != r_in.layer || r_rdata.y_pos != r_in.y_pos) begin
                    we          = 1'b1;
                    waddr       = r_at[ADDR_W-1:0];
                    wdata       = r_rdata;
                    wdata.layer = r_in.layer;
                    wdata.y_pos = r_in.y_pos;
                    n_status    = ST_CHANGED;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_NONE;
            r_count     <= '0;
            r_back      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            r_count <= n_count;
            r_back  <= n_back;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_command <= n_command;
        r_in      <= n_in;
        r_idx     <= n_idx;
        r_at      <= n_at;
        r_found   <= n_found;
        r_status  <= n_status;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_ins     <= n_ins;
        r_cur     <= n_cur;
        r_swapped <= n_swapped;
        r_hit     <= n_hit;
        if (i_cmd.out_load) begin
            r_out <= {7'd0, POS_W'(r_count), POS_W'(r_at), r_found, r_status};
        end
    end

    assign o_stat.command    = r_command;
    assign o_stat.mode       = r_mode;
    assign o_stat.found      = r_found;
    assign o_stat.idx_end    = (r_idx >= r_count);
    assign o_stat.idx_zero   = (r_idx == '0);
    assign o_stat.idx_at_ins = (r_idx == r_ins);
    assign o_stat.bs_done    = (r_lo >= r_hi);
    assign o_stat.rm_last    = (idx_inc >= {1'b0, r_count});
    assign o_stat.sp_last    = r_back ? (r_idx == '0) : (idx_inc >= {1'b0, r_count});
    assign o_stat.hit        = r_hit;
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.count_full = (r_count >= CNT_W'(TABLE_DEPTH));
    assign o_stat.count_ge2  = (r_count >= CNT_W'(2));
    assign o_stat.out_free   = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

endmodule

// ===== hdl/sot_controller.sv =====
// Command sequencer of the sprite order table.
module sot_controller import sot_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    input  t_dp_stat i_stat,
    output logic     o_s_tready,
    output t_ctl_cmd o_cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_START   = 5'd1;
    localparam logic [4:0] S_FRD     = 5'd2;
    localparam logic [4:0] S_FEV     = 5'd3;
    localparam logic [4:0] S_DECIDE  = 5'd4;
    localparam logic [4:0] S_BS_RD   = 5'd5;
    localparam logic [4:0] S_BS_EV   = 5'd6;
    localparam logic [4:0] S_SH_RD   = 5'd7;
    localparam logic [4:0] S_SH_EV   = 5'd8;
    localparam logic [4:0] S_RS_RD   = 5'd9;
    localparam logic [4:0] S_RS_EV   = 5'd10;
    localparam logic [4:0] S_RM_RD   = 5'd11;
    localparam logic [4:0] S_RM_EV   = 5'd12;
    localparam logic [4:0] S_SP_INIT = 5'd13;
    localparam logic [4:0] S_SP_R0   = 5'd14;
    localparam logic [4:0] S_SP_LD   = 5'd15;
    localparam logic [4:0] S_SP_RD   = 5'd16;
    localparam logic [4:0] S_SP_EV   = 5'd17;
    localparam logic [4:0] S_UPD_EV  = 5'd18;
    localparam logic [4:0] S_DONE    = 5'd19;

    logic [4:0] r_state, n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.op     = OP_NONE;
        o_cmd.out_load = 1'b0;
        o_s_tready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_START;
                end
            end
            S_START: begin
                if (i_stat.command == CMD_SORT && i_stat.mode == MODE_RENDER
                        && i_stat.count_ge2) begin
                    n_state = S_SP_INIT;
                end else begin
                    n_state = S_FRD;
                end
            end
            S_FRD: begin
                if (i_stat.found || i_stat.idx_end) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.op = OP_FRD;
                    n_state  = S_FEV;
                end
            end
            S_FEV: begin
                o_cmd.op = OP_FEV;
                n_state  = S_FRD;
            end
            S_DECIDE: begin
                n_state = S_DONE;
                case (i_stat.command)
                    CMD_ADD: begin
                        if (i_stat.found) begin
                            n_state = S_DONE;
                        end else if (i_stat.mode == MODE_SINGLE && !i_stat.count_zero) begin
                            o_cmd.op = OP_WR0;
                        end else if (i_stat.count_full) begin
                            o_cmd.op = OP_FULL;
                        end else if (i_stat.mode == MODE_SORTED) begin
                            o_cmd.op = OP_BS_INIT;
                            n_state  = S_BS_RD;
                        end else if (i_stat.mode == MODE_RENDER) begin
                            o_cmd.op = OP_RS_INIT;
                            n_state  = S_RS_RD;
                        end else begin
                            o_cmd.op = OP_SH_INIT;
                            n_state  = S_SH_RD;
                        end
                    end
                    CMD_REMOVE: begin
                        if (i_stat.found) begin
                            o_cmd.op = OP_RM_INIT;
                            n_state  = S_RM_RD;
                        end
                    end
                    CMD_CLEAR: begin
                        o_cmd.op = OP_CLR;
                    end
                    CMD_UPDATE: begin
                        if (i_stat.found) begin
                            o_cmd.op = OP_UPD_RD;
                            n_state  = S_UPD_EV;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_BS_RD: begin
                if (i_stat.bs_done) begin
                    o_cmd.op = OP_SH_INIT;
                    n_state  = S_SH_RD;
                end else begin
                    o_cmd.op = OP_BS_RD;
                    n_state  = S_BS_EV;
                end
            end
            S_BS_EV: begin
                o_cmd.op = OP_BS_EV;
                n_state  = S_BS_RD;
            end
            S_SH_RD: begin
                if (i_stat.idx_at_ins) begin
                    o_cmd.op = OP_PUT;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_SH_RD;
                    n_state  = S_SH_EV;
                end
            end
            S_SH_EV: begin
                o_cmd.op = OP_SH_EV;
                n_state  = S_SH_RD;
            end
            S_RS_RD: begin
                if (i_stat.hit || i_stat.idx_zero) begin
                    o_cmd.op = OP_PUT;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_SH_RD;
                    n_state  = S_RS_EV;
                end
            end
            S_RS_EV: begin
                o_cmd.op = OP_RS_EV;
                n_state  = S_RS_RD;
            end
            S_RM_RD: begin
                if (i_stat.rm_last) begin
                    o_cmd.op = OP_RM_END;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_RM_RD;
                    n_state  = S_RM_EV;
                end
            end
            S_RM_EV: begin
                o_cmd.op = OP_RM_EV;
                n_state  = S_RM_RD;
            end
            S_SP_INIT: begin
                o_cmd.op = OP_SP_INIT;
                n_state  = S_SP_R0;
            end
            S_SP_R0: begin
                o_cmd.op = OP_FRD;
                n_state  = S_SP_LD;
            end
            S_SP_LD: begin
                o_cmd.op = OP_SP_LD;
                n_state  = S_SP_RD;
            end
            S_SP_RD: begin
                if (i_stat.sp_last) begin
                    o_cmd.op = OP_SP_END;
                    n_state  = S_FRD;
                end else begin
                    o_cmd.op = OP_SP_RD;
                    n_state  = S_SP_EV;
                end
            end
            S_SP_EV: begin
                o_cmd.op = OP_SP_EV;
                n_state  = S_SP_RD;
            end
            S_UPD_EV: begin
                o_cmd.op = OP_UPD_EV;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/sprite_order_table.sv =====
// Top level of the sprite order table: stream ports, controller and datapath.
//
// Channel   Direction  Handshake                Payload
// s         in         i_s_tvalid/o_s_tready    i_s_tdata: command, sprite_key, layer, y_pos
// m         out        o_m_tvalid/i_m_tready    o_m_tdata: status, member, position, entry_total
// cfg       in         i_cfg_we                 i_cfg_data: order_mode
//
// The key scan and every shift or bubble step spend a read and an evaluate step per entry on
// the single read port of the table memory; a binary search adds such a pair per halving.
// Reset clears the entry count, the pass direction and the mode.
// A finished result waits in the output register while the next input is taken.
module sprite_order_table import sot_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // command[2:0], sprite_key[18:3], layer[34:19], y_pos[50:35]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // status[1:0], member[2], position[9:3], entry_total[16:10]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_data
);

    t_item    item;
    t_ctl_cmd cmd;
    t_dp_stat stat;

    assign item.command    = i_s_tdata[2:0];
    assign item.sprite_key = i_s_tdata[18:3];
    assign item.layer      = i_s_tdata[34:19];
    assign item.y_pos      = i_s_tdata[50:35];

    sot_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_stat     (stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    sot_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .i_m_tready (i_m_tready),
        .o_stat     (stat),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ===== hdl/sot_checker.sv =====
// Port-level assertions for the sprite order table and their bind.
module sot_checker import sot_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid) else $error("result valid after reset");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid) else $error("result dropped while stalled");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[16:10] <= POS_W'(TABLE_DEPTH))
        else $error("entry total above table depth");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[1:0] != 2'd3) else $error("undefined status code");

    a_full_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1:0] == ST_FULL |-> !o_m_tdata[2] && o_m_tdata[9:3] == '0
            && o_m_tdata[16:10] == POS_W'(TABLE_DEPTH))
        else $error("refused add reports wrong fields");

endmodule

bind sprite_order_table sot_checker u_sot_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
